// ----- rtl/assert_macros.svh -----
// assertion macros shared by the arbiter rtl
// no dependencies; pulled in by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is asserted
`define TOSA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define TOSA_IMPLY(label, clk, rst_n, ante, cons, msg) \
    `TOSA_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ----- rtl/tosa_pkg.sv -----
// types, constants and field layout for the torque output safety arbiter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package tosa_pkg;

    // field widths
    localparam int TORQUE_W   = 20;
    localparam int LIMIT_W    = 19;
    localparam int RATE_W     = 24;
    localparam int TIME_W     = 16;
    localparam int MOTORS     = 6;
    localparam int FLAGS_W    = 14;
    localparam int REASON_W   = 11;
    localparam int LATCH_W    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // request stage, four step stages, arbitration stage
    localparam int PIPE_DEPTH = 6;

    // step = floor(rate * dt / 10^6), with 10^6 = 2^6 * 15625
    localparam int P_W         = RATE_W + TIME_W;
    localparam int DIV_SHIFT   = 6;
    localparam int DIV_ODD     = 15625;
    localparam int ODD_W       = 14;
    localparam int Q_W         = P_W - DIV_SHIFT;
    localparam int Q_LO_W      = Q_W / 2;
    localparam int Q_HI_W      = Q_W - Q_LO_W;
    localparam int RECIP_SHIFT = Q_W;
    localparam int RECIP_W     = 21;
    localparam longint unsigned RECIP_M = (64'd1 << RECIP_SHIFT) / DIV_ODD;
    localparam int STEP_W      = 21;
    localparam int PP_W        = Q_HI_W + RECIP_W;
    localparam int SUM_W       = Q_W + RECIP_W;
    localparam int PROD_W      = STEP_W + ODD_W;
    localparam longint unsigned STEP_MAX =
        (((64'd1 << RATE_W) - 64'd1) * ((64'd1 << TIME_W) - 64'd1)) / 64'd1000000;

    // working width of the clamp and slew arithmetic
    localparam int WIDE_A = (TORQUE_W > LIMIT_W + 1) ? TORQUE_W : LIMIT_W + 1;
    localparam int WIDE_B = (WIDE_A > STEP_W + 1) ? WIDE_A : STEP_W + 1;
    localparam int WIDE_W = WIDE_B + 2;

    // readiness flag layout
    localparam int FLAG_ORIGIN     = 0;
    localparam int FLAG_STATE_LSB  = 1;
    localparam int FLAG_STATE_N    = 6;
    localparam int FLAG_WHEEL_LSB  = 7;
    localparam int FLAG_LQR        = 9;
    localparam int FLAG_LENGTH_LSB = 10;
    localparam int FLAG_VMC_LSB    = 12;

    // block reason bits
    localparam int BR_REMOTE  = 0;
    localparam int BR_ORIGIN  = 1;
    localparam int BR_STATE   = 2;
    localparam int BR_WHEEL   = 3;
    localparam int BR_LQR     = 4;
    localparam int BR_LENGTH  = 5;
    localparam int BR_VMC     = 6;
    localparam int BR_CONFIG  = 7;
    localparam int BR_MOTORS  = 8;
    localparam int BR_INVALID = 9;
    localparam int BR_LOCKED  = 10;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_JOINT_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_RATE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTORS       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OTHER_VALID  = 3'd5;

    // register reset values
    localparam logic [LIMIT_W-1:0] JOINT_LIMIT_RST = 19'd32768;
    localparam logic [TIME_W-1:0]  MAX_STEP_RST    = 16'd5000;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_STOP   = 2'd1,
        MODE_ENABLE = 2'd2
    } tosa_mode_t;

    typedef logic signed [TORQUE_W-1:0] torque_t;

    typedef struct packed {
        logic                remote_on;
        logic [FLAGS_W-1:0]  readiness_flags;
        logic                values_invalid;
        logic                balance_active;
        logic [TIME_W-1:0]   elapsed_time;
        torque_t             left_wheel_request;
        torque_t             right_wheel_request;
        torque_t             left_front_request;
        torque_t             left_rear_request;
        torque_t             right_front_request;
        torque_t             right_rear_request;
    } tosa_in_t;

    typedef struct packed {
        logic [1:0]          mode_command;
        logic [REASON_W-1:0] block_reason;
        logic [LATCH_W-1:0]  latched_reason;
        torque_t             left_front_out;
        torque_t             left_rear_out;
        torque_t             right_front_out;
        torque_t             right_rear_out;
        torque_t             left_wheel_out;
        torque_t             right_wheel_out;
    } tosa_out_t;

    typedef struct packed {
        logic [LIMIT_W-1:0]  joint_torque_limit;
        logic [LIMIT_W-1:0]  wheel_limit;
        logic [RATE_W-1:0]   wheel_rate_limit;
        logic [TIME_W-1:0]   max_step_time;
        logic [MOTORS-1:0]   motors_present;
        logic                other_config_valid;
    } tosa_cfg_t;

    typedef struct packed {
        logic                dt_zero;
        logic [STEP_W-1:0]   step;
    } tosa_step_t;

endpackage

// ----- rtl/tosa_step_calc.sv -----
// wheel slew step pipeline: clamps elapsed time, forms rate * dt and divides
// by 10^6 through a reciprocal multiply with one correction; uses tosa_pkg
`timescale 1ns / 1ps

module tosa_step_calc
    import tosa_pkg::*;
(
    input  logic                   clk,
    input  logic [PIPE_DEPTH-1:1]  load,
    input  logic [TIME_W-1:0]      elapsed_time,
    input  tosa_cfg_t              cfg,
    output tosa_step_t             step
);

    logic [PIPE_DEPTH-1:1] zero_reg;

    logic [TIME_W-1:0]  dt;
    logic [P_W-1:0]     prod1_next;
    logic [P_W-1:0]     prod1_reg;

    logic [Q_W-1:0]     quot2_next;
    logic [PP_W-1:0]    pp_hi_next;
    logic [PP_W-1:0]    pp_lo_next;
    logic [Q_W-1:0]     quot2_reg;
    logic [PP_W-1:0]    pp_hi_reg;
    logic [PP_W-1:0]    pp_lo_reg;

    logic [SUM_W-1:0]   pp_sum;
    logic [STEP_W-1:0]  est3_next;
    logic [Q_W-1:0]     quot3_reg;
    logic [STEP_W-1:0]  est3_reg;

    logic [PROD_W-1:0]  back4_next;
    logic [Q_W-1:0]     quot4_reg;
    logic [STEP_W-1:0]  est4_reg;
    logic [PROD_W-1:0]  back4_reg;

    logic [Q_W-1:0]     rem;
    logic [STEP_W-1:0]  step5_next;
    logic [STEP_W-1:0]  step5_reg;

    always_comb
    begin
        dt         = (elapsed_time > cfg.max_step_time) ? cfg.max_step_time : elapsed_time;
        prod1_next = P_W'(cfg.wheel_rate_limit) * P_W'(dt);

        // drop the power-of-two part of 10^6 first
        quot2_next = prod1_reg[P_W-1:DIV_SHIFT];
        pp_hi_next = PP_W'(quot2_next[Q_W-1:Q_LO_W]) * PP_W'(RECIP_M);
        pp_lo_next = PP_W'(quot2_next[Q_LO_W-1:0]) * PP_W'(RECIP_M);

        // estimate is the true quotient or one below it
        pp_sum     = (SUM_W'(pp_hi_reg) << Q_LO_W) + SUM_W'(pp_lo_reg);
        est3_next  = pp_sum[SUM_W-1:RECIP_SHIFT];

        back4_next = PROD_W'(est3_reg) * PROD_W'(DIV_ODD);

        rem        = quot4_reg - back4_reg[Q_W-1:0];
        step5_next = (rem >= Q_W'(DIV_ODD)) ? est4_reg + STEP_W'(1) : est4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            prod1_reg   <= prod1_next;
            zero_reg[1] <= (dt == '0);
        end
        if (load[2])
        begin
            quot2_reg   <= quot2_next;
            pp_hi_reg   <= pp_hi_next;
            pp_lo_reg   <= pp_lo_next;
            zero_reg[2] <= zero_reg[1];
        end
        if (load[3])
        begin
            quot3_reg   <= quot2_reg;
            est3_reg    <= est3_next;
            zero_reg[3] <= zero_reg[2];
        end
        if (load[4])
        begin
            quot4_reg   <= quot3_reg;
            est4_reg    <= est3_reg;
            back4_reg   <= back4_next;
            zero_reg[4] <= zero_reg[3];
        end
        if (load[5])
        begin
            step5_reg   <= step5_next;
            zero_reg[5] <= zero_reg[4];
        end
    end

    assign step.dt_zero = zero_reg[PIPE_DEPTH-1];
    assign step.step    = step5_reg;

endmodule

// ----- rtl/tosa_core.sv -----
// arbitration core: block-reason mask, enable and fault-lock latches, torque
// clamps and wheel slew against the previous output; uses tosa_pkg
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tosa_core
    import tosa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       commit,
    input  tosa_in_t   item,
    input  tosa_cfg_t  cfg,
    input  tosa_step_t step,
    output tosa_out_t  result
);

    logic                   fault_lock_reg;
    logic                   fault_lock_next;
    logic                   once_enabled_reg;
    logic                   once_enabled_next;
    logic                   motors_on_reg;
    logic                   motors_on_next;
    logic [LATCH_W-1:0]     latched_block_reg;
    logic [LATCH_W-1:0]     latched_block_next;
    torque_t                prev_wheel_reg [2];
    torque_t                prev_wheel_next [2];

    logic [LATCH_W-1:0]     cond;
    logic [REASON_W-1:0]    reason;
    logic                   apply;
    tosa_mode_t             mode;
    torque_t                wheel_req [2];
    logic signed [WIDE_W-1:0] tgt;
    logic signed [WIDE_W-1:0] prev_w;
    logic signed [WIDE_W-1:0] delta;
    logic signed [WIDE_W-1:0] step_w;
    logic signed [WIDE_W-1:0] slewed;

    function automatic logic signed [WIDE_W-1:0] sext_torque(input torque_t t);
        return {{(WIDE_W-TORQUE_W){t[TORQUE_W-1]}}, t};
    endfunction

    // a zero limit clamps to zero on its own
    function automatic torque_t clamp_abs(input torque_t t, input logic [LIMIT_W-1:0] lim);
        logic signed [WIDE_W-1:0] tw;
        logic signed [WIDE_W-1:0] lw;
        logic signed [WIDE_W-1:0] cw;
        tw = sext_torque(t);
        lw = {{(WIDE_W-LIMIT_W){1'b0}}, lim};
        if (tw > lw)
            cw = lw;
        else if (tw < -lw)
            cw = -lw;
        else
            cw = tw;
        return cw[TORQUE_W-1:0];
    endfunction

    always_comb
    begin
        cond               = '0;
        cond[BR_ORIGIN]    = !item.readiness_flags[FLAG_ORIGIN];
        cond[BR_STATE]     = ~&item.readiness_flags[FLAG_STATE_LSB +: FLAG_STATE_N];
        cond[BR_WHEEL]     = ~&item.readiness_flags[FLAG_WHEEL_LSB +: 2];
        cond[BR_LQR]       = !item.readiness_flags[FLAG_LQR];
        cond[BR_LENGTH]    = ~&item.readiness_flags[FLAG_LENGTH_LSB +: 2];
        cond[BR_VMC]       = ~&item.readiness_flags[FLAG_VMC_LSB +: 2];
        cond[BR_CONFIG]    = (cfg.wheel_limit == '0) || (cfg.wheel_rate_limit == '0)
                             || !cfg.other_config_valid;
        cond[BR_MOTORS]    = ~&cfg.motors_present;
        cond[BR_INVALID]   = item.values_invalid;

        apply              = 1'b0;
        fault_lock_next    = fault_lock_reg;
        once_enabled_next  = once_enabled_reg;
        latched_block_next = latched_block_reg;
        reason             = '0;

        if (!item.remote_on)
        begin
            fault_lock_next   = 1'b0;
            once_enabled_next = 1'b0;
            reason[BR_REMOTE] = 1'b1;
        end
        else
        begin
            if (!fault_lock_reg && (cond == '0))
            begin
                apply             = 1'b1;
                once_enabled_next = 1'b1;
            end
            else if (once_enabled_reg && !fault_lock_reg)
            begin
                // failure after enable: lock until the remote goes off
                latched_block_next = cond;
                fault_lock_next    = 1'b1;
            end
            reason             = {1'b0, cond};
            reason[BR_LOCKED]  = fault_lock_next;
        end

        motors_on_next = apply;
        if (apply == motors_on_reg)
            mode = MODE_NONE;
        else if (apply)
            mode = MODE_ENABLE;
        else
            mode = MODE_STOP;

        wheel_req[0] = item.left_wheel_request;
        wheel_req[1] = item.right_wheel_request;
        for (int i = 0; i < 2; i++)
        begin
            tgt    = sext_torque(clamp_abs(item.balance_active ? wheel_req[i] : '0,
                                           cfg.wheel_limit));
            prev_w = sext_torque(prev_wheel_reg[i]);
            step_w = {{(WIDE_W-STEP_W){1'b0}}, step.step};
            delta  = tgt - prev_w;
            if (delta > step_w)
                slewed = prev_w + step_w;
            else if (delta < -step_w)
                slewed = prev_w - step_w;
            else
                slewed = tgt;
            prev_wheel_next[i] = (apply && !step.dt_zero) ? slewed[TORQUE_W-1:0] : '0;
        end

        result.mode_command    = mode;
        result.block_reason    = reason;
        result.latched_reason  = latched_block_next;
        result.left_front_out  = apply ? clamp_abs(item.left_front_request,
                                                   cfg.joint_torque_limit) : '0;
        result.left_rear_out   = apply ? clamp_abs(item.left_rear_request,
                                                   cfg.joint_torque_limit) : '0;
        result.right_front_out = apply ? clamp_abs(item.right_front_request,
                                                   cfg.joint_torque_limit) : '0;
        result.right_rear_out  = apply ? clamp_abs(item.right_rear_request,
                                                   cfg.joint_torque_limit) : '0;
        result.left_wheel_out  = prev_wheel_next[0];
        result.right_wheel_out = prev_wheel_next[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_lock_reg    <= 1'b0;
            once_enabled_reg  <= 1'b0;
            motors_on_reg     <= 1'b0;
            latched_block_reg <= '0;
            prev_wheel_reg[0] <= '0;
            prev_wheel_reg[1] <= '0;
        end
        else if (commit)
        begin
            fault_lock_reg    <= fault_lock_next;
            once_enabled_reg  <= once_enabled_next;
            motors_on_reg     <= motors_on_next;
            latched_block_reg <= latched_block_next;
            prev_wheel_reg[0] <= prev_wheel_next[0];
            prev_wheel_reg[1] <= prev_wheel_next[1];
        end
    end

    `TOSA_IMPLY(a_lock_needs_enable, clk, rst_n, fault_lock_reg, once_enabled_reg, "fault lock set without prior enable")
    `TOSA_IMPLY(a_motors_on_unlocked, clk, rst_n, motors_on_reg, once_enabled_reg && !fault_lock_reg, "motors on while locked or never enabled")
    `TOSA_IMPLY(a_enable_only_clear, clk, rst_n, commit && (result.mode_command == MODE_ENABLE), result.block_reason == '0, "enable commanded with a block reason")

endmodule

// ----- rtl/torque_output_safety_arbiter.sv -----
// top level of the torque output safety arbiter: configuration registers,
// request pipeline and result register; uses tosa_pkg, tosa_step_calc, tosa_core
`timescale 1ns / 1ps
`include "assert_macros.svh"

// One request per clock is taken unless every stage is full and the result
// is held, and one result comes out per request, in order. A request first
// passes the wheel slew step pipeline (rate * elapsed time while the request
// sits in the input stage, then a reciprocal multiply and a correction for
// the division by one million), then the arbitration stage where the enable
// latch, fault lock and previous wheel torques are read and updated, and the
// result then waits in the result register until taken. Each stage stalls
// only while the one after it is full and held, so requests keep entering
// while a result waits, until every stage is full. Configuration writes are
// taken at once (cfg_ready is always high) and must only be made while no
// request is in flight.

module torque_output_safety_arbiter
    import tosa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  req_valid,
    output logic                  req_ready,
    input  tosa_in_t              req,

    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output tosa_out_t             rsp,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    tosa_cfg_t              cfg_reg;
    logic [PIPE_DEPTH-1:0]  valid_reg;
    tosa_in_t               item_reg [PIPE_DEPTH];
    logic                   rsp_valid_reg;
    tosa_out_t              rsp_reg;

    logic [PIPE_DEPTH-1:0]  take;
    logic                   take_out;
    logic                   commit;
    tosa_step_t             step;
    tosa_out_t              result;

    // a stage loads when empty or when its contents move on
    always_comb
    begin
        take_out             = !rsp_valid_reg || rsp_ready;
        take[PIPE_DEPTH-1]   = !valid_reg[PIPE_DEPTH-1] || take_out;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--)
            take[k] = !valid_reg[k] || take[k+1];
    end

    assign commit    = take_out && valid_reg[PIPE_DEPTH-1];
    assign req_ready = take[0];
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.joint_torque_limit <= JOINT_LIMIT_RST;
            cfg_reg.wheel_limit        <= '0;
            cfg_reg.wheel_rate_limit   <= '0;
            cfg_reg.max_step_time      <= MAX_STEP_RST;
            cfg_reg.motors_present     <= '0;
            cfg_reg.other_config_valid <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_JOINT_LIMIT: cfg_reg.joint_torque_limit <= cfg_data[LIMIT_W-1:0];
                CFG_WHEEL_LIMIT: cfg_reg.wheel_limit        <= cfg_data[LIMIT_W-1:0];
                CFG_WHEEL_RATE:  cfg_reg.wheel_rate_limit   <= cfg_data[RATE_W-1:0];
                CFG_MAX_STEP:    cfg_reg.max_step_time      <= cfg_data[TIME_W-1:0];
                CFG_MOTORS:      cfg_reg.motors_present     <= cfg_data[MOTORS-1:0];
                CFG_OTHER_VALID: cfg_reg.other_config_valid <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (take[0])
                valid_reg[0] <= req_valid;
            for (int k = 1; k < PIPE_DEPTH; k++)
                if (take[k])
                    valid_reg[k] <= valid_reg[k-1];
            if (take_out)
                rsp_valid_reg <= valid_reg[PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take[0])
            item_reg[0] <= req;
        for (int k = 1; k < PIPE_DEPTH; k++)
            if (take[k])
                item_reg[k] <= item_reg[k-1];
        if (commit)
            rsp_reg <= result;
    end

    tosa_step_calc u_step
    (
        .clk          (clk),
        .load         (take[PIPE_DEPTH-1:1]),
        .elapsed_time (item_reg[0].elapsed_time),
        .cfg          (cfg_reg),
        .step         (step)
    );

    tosa_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (commit),
        .item   (item_reg[PIPE_DEPTH-1]),
        .cfg    (cfg_reg),
        .step   (step),
        .result (result)
    );

    `TOSA_IMPLY(a_full_stall_blocks, clk, rst_n, (&valid_reg) && rsp_valid_reg && !rsp_ready, !req_ready, "request taken while every stage is held")
    `TOSA_IMPLY(a_step_in_range, clk, rst_n, valid_reg[PIPE_DEPTH-1], step.step <= STEP_W'(STEP_MAX), "slew step beyond its largest value")

endmodule
